/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define DPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/dpc_pkg.sv */
// Shared types, widths and saturation helpers for the DPCM codec.
// No dependencies.
package dpc_pkg;

    localparam int SAMPLE_W = 11;
    localparam int WIDE_W   = 13;
    localparam int TDATA_W  = 16;

    // Control handed from the stream stage to the predictor core.
    typedef struct packed {
        logic fire;
        logic decode;
        logic start;
    } t_step_ctl;

    // Saturate to the signed 11-bit range.
    function automatic logic signed [SAMPLE_W-1:0] sat11(input logic signed [WIDE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v < -13'sd1024) begin
            r = -11'sd1024;
        end else if (v > 13'sd1023) begin
            r = 11'sd1023;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Saturate to 0..255, result kept signed at 11 bits.
    function automatic logic signed [SAMPLE_W-1:0] sat_byte(input logic signed [WIDE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v < 13'sd0) begin
            r = 11'sd0;
        end else if (v > 13'sd255) begin
            r = 11'sd255;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/dpc_core.sv */
// Predictor, quantiser and reconstruction history of the DPCM codec.
// Depends on dpc_pkg.
module dpc_core import dpc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_step_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_coded
);

    logic signed [SAMPLE_W-1:0] r_recon_one;
    logic signed [SAMPLE_W-1:0] r_recon_two;
    logic signed [SAMPLE_W-1:0] n_recon_one;

    logic signed [SAMPLE_W:0]   w_sum;
    logic signed [SAMPLE_W:0]   w_half;
    logic signed [WIDE_W-1:0]   w_pred;
    logic signed [WIDE_W-1:0]   w_x;
    logic signed [SAMPLE_W-1:0] w_xc;
    logic signed [WIDE_W-1:0]   w_t;
    logic signed [WIDE_W-1:0]   w_qdiv;
    logic signed [WIDE_W-1:0]   w_q;
    logic signed [SAMPLE_W-1:0] w_qc;
    logic signed [SAMPLE_W-1:0] w_enc_recon;
    logic signed [SAMPLE_W-1:0] w_dec_recon;

    always_comb begin
        // Average of the two histories, halving rounds toward zero.
        w_sum  = {r_recon_one[SAMPLE_W-1], r_recon_one} + {r_recon_two[SAMPLE_W-1], r_recon_two};
        w_half = (w_sum + $signed({{SAMPLE_W{1'b0}}, w_sum[SAMPLE_W]})) >>> 1;
        w_pred = {w_half[SAMPLE_W], w_half};
        w_x    = {{(WIDE_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
        w_xc   = sat_byte(w_x);

        // Quantise: 16*trunc((255+e)/16) - 248.
        w_t    = 13'sd255 + {{(WIDE_W-SAMPLE_W){w_xc[SAMPLE_W-1]}}, w_xc} - w_pred;
        w_qdiv = (w_t + (w_t[WIDE_W-1] ? 13'sd15 : 13'sd0)) >>> 4;
        w_q    = (w_qdiv <<< 4) - 13'sd248;
        w_qc   = sat11(w_q);
        w_enc_recon = sat11(w_pred + {{(WIDE_W-SAMPLE_W){w_qc[SAMPLE_W-1]}}, w_qc});
        w_dec_recon = sat_byte(w_pred + w_x);

        if (!i_ctl.decode) begin
            o_coded     = i_ctl.start ? w_xc : w_qc;
            n_recon_one = i_ctl.start ? w_xc : w_enc_recon;
        end else begin
            o_coded     = i_ctl.start ? i_sample : w_dec_recon;
            n_recon_one = o_coded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recon_one <= '0;
            r_recon_two <= '0;
        end else if (i_ctl.fire) begin
            r_recon_one <= n_recon_one;
            // A start beat seeds both histories with the same value.
            r_recon_two <= i_ctl.start ? n_recon_one : r_recon_one;
        end
    end

endmodule

/* rtl/dpcm_codec.sv */
// Channel    Dir  Payload
// s_axis     in   tdata[10:0] sample_value, tuser[0] start_of_sequence
// m_axis     out  tdata[10:0] coded_value
// cfg        in   i_cfg_data[0] decode_mode (always ready)
// One beat per clock sustained while the sink is ready; each beat passes the input register, then the result register.
// The history update is registered on the same edge as the result, so items follow back to back.
// Reset is synchronous, active low, and clears valids, mode and both histories.
// An output stall holds the result register; one more beat is absorbed in the input register.
// Top level of the DPCM codec: stream registers and mode register.
// Depends on dpc_pkg, dpc_core and assert_macros.svh.
`include "assert_macros.svh"
module dpcm_codec import dpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [10:0] sample_value
    input  logic [0:0]         s_axis_tuser,   // [0] start_of_sequence
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [10:0] coded_value
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_data      // [0] decode_mode
);

    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_in_sample;
    logic                       r_in_start;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_coded;
    logic                       r_decode_mode;

    logic                       w_advance;
    logic signed [SAMPLE_W-1:0] w_coded;
    t_step_ctl                  w_ctl;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, r_out_coded};
    assign o_cfg_ready   = 1'b1;

    assign w_ctl.fire   = w_advance;
    assign w_ctl.decode = r_decode_mode;
    assign w_ctl.start  = r_in_start;

    dpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (r_in_sample),
        .o_coded  (w_coded)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_decode_mode <= i_cfg_data[0];
        end
    end

    // Input register: take a beat whenever the slot is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_in_start  <= s_axis_tuser[0];
        end
    end

    // Result register: hold while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_coded <= w_coded;
        end
    end

    `DPC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !r_out_valid, "output valid after reset")
    `DPC_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready), "input stalled with room left")
    `DPC_ASSERT(a_pending_kept, i_clk, i_rst_n, (r_in_valid && !w_advance) |=> r_in_valid, "pending beat dropped")
    `DPC_ASSERT(a_decode_range, i_clk, i_rst_n, (w_advance && r_decode_mode && !r_in_start) |=> (r_out_coded[SAMPLE_W-1:8] == 3'b000), "decoded sample outside 0..255")
    `DPC_ASSERT(a_encode_grid, i_clk, i_rst_n, (w_advance && !r_decode_mode && !r_in_start) |=> ((r_out_coded[3:0] == 4'd8) || (r_out_coded == -11'sd1024) || (r_out_coded == 11'sd1023)), "quantised error off the step grid")

endmodule

/* test/tb_dpcm_codec.sv */
// Self-checking testbench for dpcm_codec: stream driver, output monitor and a
// behavioural model of the two-tap DPCM predictor in both modes.
// Depends on dpc_pkg and the dpcm_codec RTL.
`timescale 1ns / 100ps

module tb_dpcm_codec import dpc_pkg::*;;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_codec_mode;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sos;
    } t_sample_beat;

    localparam int PAD_W = TDATA_W - SAMPLE_W;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic [0:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_data;

    // Model state
    t_codec_mode codec_mode = MODE_ENCODE;
    int          recon_last = 0;
    int          recon_prev = 0;

    t_sample_beat               pending_beats[$];
    logic signed [SAMPLE_W-1:0] coded_expect[$];

    bit drive_en     = 1'b0;
    bit no_idle      = 1'b0;
    bit sample_took  = 1'b0;
    bit cfg_taken    = 1'b0;
    int in_gap       = 0;
    int out_hold     = 0;
    int err_count    = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int beats_queued = 0;
    int starts_in    = 0;
    int mode_writes  = 0;

    dpcm_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [10:0] sample_value
        .s_axis_tuser  (s_axis_tuser),   // [0] start_of_sequence
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [10:0] coded_value
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)      // [0] decode_mode
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(5_000_000);
        $display("Timeout with %0d results outstanding", coded_expect.size());
        $display("dpcm_codec test failed");
        $finish;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Advance the predictor history by one sample and return the coded value.
    function automatic logic signed [SAMPLE_W-1:0] dpcm_step(
        input logic signed [SAMPLE_W-1:0] sample, input logic sos);
        int x;
        int pred;
        int err;
        int r;
        x    = sample;
        pred = (recon_last + recon_prev) / 2;
        if (codec_mode == MODE_ENCODE) begin
            x = clip(x, 0, 255);
        end
        if (sos) begin
            r          = x;
            recon_last = x;
            recon_prev = x;
        end else if (codec_mode == MODE_ENCODE) begin
            err        = x - pred;
            r          = clip(16 * ((255 + err) / 16) - 248, -1024, 1023);
            recon_prev = recon_last;
            recon_last = clip(pred + r, -1024, 1023);
        end else begin
            r          = clip(pred + x, 0, 255);
            recon_prev = recon_last;
            recon_last = r;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic add_beat(input int sample, input bit sos);
        t_sample_beat b;
        b.sample = sample[SAMPLE_W-1:0];
        b.sos    = sos;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Input side: accept, predict
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            coded_expect.push_back(dpcm_step(s_axis_tdata[SAMPLE_W-1:0], s_axis_tuser[0]));
            sample_took = 1'b1;
            beats_in++;
            if (s_axis_tuser[0]) begin
                starts_in++;
            end
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            codec_mode = t_codec_mode'(i_cfg_data[0]);
            cfg_taken  = 1'b1;
            mode_writes++;
        end
    end

    // Stream driver: present the next beat once the current one is taken
    always @(negedge i_clk) begin
        t_sample_beat b;
        if (!s_axis_tvalid || sample_took) begin
            sample_took = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (drive_en && pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{PAD_W{1'b0}}, b.sample};
                s_axis_tuser  <= b.sos;
                in_gap = idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            out_hold = idle_len();
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (coded_expect.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat, coded_value %0d",
                    $signed(m_axis_tdata[SAMPLE_W-1:0])));
            end else begin
                want = coded_expect.pop_front();
                if (m_axis_tdata !== {{PAD_W{1'b0}}, want}) begin
                    flag_mismatch($sformatf("beat %0d coded_value %0d (tdata %h), want %0d",
                        beats_out, $signed(m_axis_tdata[SAMPLE_W-1:0]), m_axis_tdata, want));
                end
            end
        end
    end

    task automatic write_mode(input t_codec_mode m);
        @(negedge i_clk);
        cfg_taken = 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every queued beat has gone in and come out again
    task automatic drain();
        do @(negedge i_clk);
        while (beats_out < beats_queued);
    endtask

    function automatic int enc_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
            return $urandom_range(0, 255);
        end
        if (roll < 9) begin
            return ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 3) : $urandom_range(0, 3);
        end
        return $urandom_range(0, 2047);
    endfunction

    function automatic int dec_error();
        if ($urandom_range(0, 3) != 0) begin
            return 16 * $urandom_range(0, 31) - 248;
        end
        return $urandom_range(0, 2047);
    endfunction

    // Well-formed runs (seed then a stretch of samples) plus some unseeded noise
    task automatic queue_runs(input t_codec_mode m, input int count);
        int n;
        int len;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) != 0) begin
                if (m == MODE_ENCODE || $urandom_range(0, 6) != 0) begin
                    add_beat((m == MODE_ENCODE) ? enc_sample() : $urandom_range(0, 255), 1'b1);
                end else begin
                    add_beat($urandom_range(0, 2047), 1'b1);
                end
                n++;
            end
            len = $urandom_range(1, 30);
            repeat (len) begin
                add_beat((m == MODE_ENCODE) ? enc_sample() : dec_error(), 1'b0);
                n++;
            end
        end
    endtask

    initial begin
        t_codec_mode m;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        drive_en = 1'b1;

        // Encode straight out of reset, first sample unseeded against zero history
        add_beat(100, 1'b0);
        add_beat(1023, 1'b0);
        add_beat(-1024, 1'b0);
        add_beat(0, 1'b1);
        add_beat(255, 1'b0);
        add_beat(-1, 1'b0);
        add_beat(1023, 1'b1);
        add_beat(0, 1'b0);
        add_beat(128, 1'b0);
        drain();

        // Decode with seeds at both ends of the field range
        write_mode(MODE_DECODE);
        add_beat(-1024, 1'b1);
        add_beat(1023, 1'b0);
        add_beat(1023, 1'b1);
        add_beat(-1024, 1'b0);
        add_beat(248, 1'b0);
        add_beat(0, 1'b1);
        add_beat(-248, 1'b0);
        add_beat(8, 1'b0);
        add_beat(-1024, 1'b1);
        drain();

        // Switch back mid-sequence: the negative seed drives the error to saturation
        write_mode(MODE_ENCODE);
        add_beat(255, 1'b0);
        add_beat(255, 1'b0);
        add_beat(0, 1'b0);
        drain();

        m = MODE_ENCODE;
        repeat (6) begin
            m = (m == MODE_ENCODE) ? MODE_DECODE : MODE_ENCODE;
            no_idle = ($urandom_range(0, 3) == 0);
            write_mode(m);
            queue_runs(m, 115);
            drain();
        end
        repeat (4) @(negedge i_clk);

        $display("Ran %0d beats in (%0d sequence starts), %0d beats out, %0d mode writes",
            beats_in, starts_in, beats_out, mode_writes);
        if (err_count == 0) begin
            $display("dpcm_codec test passed");
        end else begin
            $display("%0d mismatches", err_count);
            $display("dpcm_codec test failed");
        end
        $finish;
    end

endmodule
